[rtl/core/b64d_pkg.sv]
// Shared types, constants and the character classifier for the base64url decoder.
`timescale 1ns / 1ps
package b64d_pkg;

   // Alphabet values of the two URL-safe punctuation characters
   localparam logic [5:0] VAL_DASH       = 6'd62;
   localparam logic [5:0] VAL_UNDERSCORE = 6'd63;
   localparam logic [3:0] LOW_FOUR       = 4'hf;

   // Position of a character within its four-character group
   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_THIRD  = 2'd2;
   localparam logic [1:0] POS_FOURTH = 2'd3;

   // One classified character as it travels from front to back
   typedef struct packed {
      logic [5:0] value;     // 6-bit alphabet value, zero when invalid
      logic       ok;        // character belongs to the alphabet
      logic       is_final;  // last character of the text
   } b64d_item_type;

   // Queue status seen by the front and the back
   typedef struct packed {
      logic empty;
      logic full;
   } b64d_qstat_type;

   // Map an ASCII character to its 6-bit value; ok drops for anything else.
   function automatic b64d_item_type classify(input logic [7:0] sym, input logic fin);
      b64d_item_type item;
      item.is_final = fin;
      item.ok       = 1'b1;
      item.value    = 6'd0;
      if (sym >= 8'h41 && sym <= 8'h5a) begin
         item.value = 6'(sym - 8'h41);
      end else if (sym >= 8'h61 && sym <= 8'h7a) begin
         item.value = 6'(sym - 8'h61 + 8'd26);
      end else if (sym >= 8'h30 && sym <= 8'h39) begin
         item.value = 6'(sym - 8'h30 + 8'd52);
      end else if (sym == 8'h2d) begin
         item.value = VAL_DASH;
      end else if (sym == 8'h5f) begin
         item.value = VAL_UNDERSCORE;
      end else begin
         item.ok = 1'b0;
      end
      return item;
   endfunction

endpackage

[rtl/core/b64d_front.sv]
// Front end: accepts characters and classifies them into queue entries.
`timescale 1ns / 1ps
module b64d_front
   import b64d_pkg::*;
(
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic [7:0]     req_symbol,
   input  logic           req_is_final,
   input  b64d_qstat_type qstat,
   output logic           push,
   output b64d_item_type  push_item
);

   // Stall straight from the registered queue status; refuse everything in reset
   assign req_stall = qstat.full || reset;
   assign push      = req_valid && !qstat.full && !reset;
   assign push_item = classify(req_symbol, req_is_final);

endmodule

[rtl/core/b64d_queue.sv]
// Short FIFO of classified characters between front and back.
`timescale 1ns / 1ps
module b64d_queue
   import b64d_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  b64d_item_type  push_item,
   input  logic           pop,
   output b64d_item_type  head_item,
   output b64d_qstat_type qstat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   b64d_item_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item   = slot_ff[rd_ptr_ff];
   assign qstat.empty = (count_ff == '0);
   assign qstat.full  = (count_ff == FULL_CNT);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> !push)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      qstat.empty |-> !pop)
      else $error("queue read while empty");

endmodule

[rtl/core/b64d_back.sv]
// Back end: group tracking, bit splicing and the result register.
`timescale 1ns / 1ps
module b64d_back
   import b64d_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  b64d_item_type  head_item,
   input  b64d_qstat_type qstat,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [7:0]     rsp_data_byte,
   output logic           rsp_has_byte,
   output logic           rsp_end_of_text,
   output logic           rsp_bad_input
);

   logic [1:0] pos_ff,  pos_in;
   logic [5:0] pend_ff, pend_in;
   logic       err_ff,  err_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff,  out_byte_in;
   logic       out_has_ff,   out_has_in;
   logic       out_end_ff,   out_end_in;
   logic       out_bad_ff,   out_bad_in;

   logic       tail_bad;
   logic       err_now;
   logic       emit;
   logic [5:0] v;

   // Take the head when the result register is free or draining this cycle
   assign pop     = !qstat.empty && (!out_valid_ff || !rsp_stall);
   assign v       = head_item.value;
   assign err_now = err_ff || !head_item.ok;

   always_comb begin
      out_byte_in = 8'd0;
      out_has_in  = 1'b1;
      pend_in     = pend_ff;
      tail_bad    = 1'b0;
      case (pos_ff)
         POS_FIRST: begin
            out_has_in = 1'b0;
            pend_in    = v;
            tail_bad   = 1'b1;
         end
         POS_SECOND: begin
            out_byte_in = {pend_ff, v[5:4]};
            pend_in     = {2'b00, v[3:0] & LOW_FOUR};
            tail_bad    = (v[3:0] != 4'd0);
         end
         POS_THIRD: begin
            out_byte_in = {pend_ff[3:0], v[5:2]};
            pend_in     = {4'd0, v[1:0]};
            tail_bad    = (v[1:0] != 2'd0);
         end
         default: begin
            out_byte_in = {pend_ff[1:0], v};
            pend_in     = 6'd0;
         end
      endcase
      emit       = out_has_in || head_item.is_final;
      out_end_in = head_item.is_final;
      out_bad_in = head_item.is_final && (tail_bad || err_now);
      pos_in     = pos_ff + 2'd1;
      err_in     = err_now;
      // The final character returns the group state to its reset values
      if (head_item.is_final) begin
         pos_in  = POS_FIRST;
         pend_in = 6'd0;
         err_in  = 1'b0;
      end
      out_valid_in = out_valid_ff && rsp_stall;
      if (pop && emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_FIRST;
         pend_ff      <= 6'd0;
         err_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            pos_ff  <= pos_in;
            pend_ff <= pend_in;
            err_ff  <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         out_byte_ff <= out_byte_in;
         out_has_ff  <= out_has_in;
         out_end_ff  <= out_end_in;
         out_bad_ff  <= out_bad_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_data_byte   = out_byte_ff;
   assign rsp_has_byte    = out_has_ff;
   assign rsp_end_of_text = out_end_ff;
   assign rsp_bad_input   = out_bad_ff;

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (pop && head_item.is_final) |=> (pos_ff == POS_FIRST && !err_ff && pend_ff == 6'd0))
      else $error("group state not cleared after final character");

   a_bad_only_at_end: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (!out_bad_ff || out_end_ff))
      else $error("bad_input reported before end of text");

endmodule

[rtl/core/base64url_decoder_unit.sv]
// Top level of the unpadded base64url decoder.
`timescale 1ns / 1ps
//
//  Channel | Direction | Handshake        | Payload
//  --------+-----------+------------------+---------------------------------------------
//  req     | in        | valid / stall    | symbol[7:0], is_final
//  rsp     | out       | valid / stall    | data_byte[7:0], has_byte, end_of_text, bad_input
//
//  One character per cycle sustained while rsp is not stalled; a result is offered
//  on rsp once its character has been written to a queue slot and then to the
//  result register.
//  Throughput is set by the back end, retiring one queue entry per cycle unless rsp stalls.
//  Synchronous active-high reset empties the queue and clears group state.
//  req_stall is high during reset and otherwise only when the character queue
//  is full; a stalled rsp holds the result register, and the queue absorbs up
//  to QUEUE_DEPTH characters.
//  First characters of a group that are not final produce no transaction.
//
module base64url_decoder_unit
   import b64d_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_symbol,
   input  logic       req_is_final,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_has_byte,
   output logic       rsp_end_of_text,
   output logic       rsp_bad_input
);

   b64d_qstat_type qstat;
   b64d_item_type  push_item;
   b64d_item_type  head_item;
   logic           push;
   logic           pop;

   // Classify each accepted transaction and queue it
   b64d_front u_front (
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_symbol   (req_symbol),
      .req_is_final (req_is_final),
      .qstat        (qstat),
      .push         (push),
      .push_item    (push_item)
   );

   // Decouple the front from back-pressure on the result side
   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .qstat     (qstat)
   );

   // Splice bits into bytes and hold the outgoing transaction
   b64d_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_item       (head_item),
      .qstat           (qstat),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_has_byte    (rsp_has_byte),
      .rsp_end_of_text (rsp_end_of_text),
      .rsp_bad_input   (rsp_bad_input)
   );

endmodule
